// ----- rtl/prpi_pkg.sv -----
package prpi_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 8192;

   localparam int VIDX_W  = $clog2(MAX_VERTICES);
   localparam int VCNT_W  = VIDX_W + 1;
   localparam int EIDX_W  = $clog2(MAX_EDGES);
   localparam int ECNT_W  = EIDX_W + 1;

   localparam int VAL_W   = 32;
   localparam int DAMP_W  = 16;
   localparam int ITER_W  = 8;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int TERM_W  = PROD_W - 30;
   localparam int ACC_W   = TERM_W + ECNT_W;
   localparam int MIX_W   = VAL_W + DAMP_W;
   localparam int RESID_W = VAL_W + VCNT_W;

   localparam logic [DAMP_W-1:0] ONE_Q15      = DAMP_W'(32768);
   localparam logic [DAMP_W-1:0] DAMP_RESET   = DAMP_W'(27853);
   localparam logic [ITER_W-1:0] ITER_RESET   = ITER_W'(40);

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_VERTEX = 3'd1,
      OP_EDGE   = 3'd2,
      OP_RUN    = 3'd3,
      OP_READ   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_NO_RES  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_DAMPING = 1'b0,
      CSR_ITERS   = 1'b1
   } csr_index_type;

   function automatic logic [VAL_W-1:0] sat_acc(input logic [ACC_W-1:0] v);
      sat_acc = (v[ACC_W-1:VAL_W] != '0) ? '1 : v[VAL_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] sat_resid(input logic [RESID_W-1:0] v);
      sat_resid = (v[RESID_W-1:VAL_W] != '0) ? '1 : v[VAL_W-1:0];
   endfunction

endpackage

// ----- rtl/prpi_ram.sv -----
module prpi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/pagerank_power_iteration_unit.sv -----
// Load, clear and rejected requests never leave idle: the response strobes
// in the cycle after acceptance and busy never rises. A rank read passes
// through the read state before it strobes. A run walks every vertex and edge
// per iteration through the single read port of the rank memories.
// Synchronous active-high reset clears counters, flags and configuration; the
// graph memories are not cleared. The receiver cannot stall a response.
module pagerank_power_iteration_unit
   import prpi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_opcode,
   input  logic [VAL_W-1:0]    req_prior_value,
   input  logic [VIDX_W-1:0]   req_neighbor,
   input  logic [VAL_W-1:0]    req_edge_weight,
   input  logic [VIDX_W-1:0]   req_vertex_index,
   output logic                rsp_strobe,
   output logic [VIDX_W-1:0]   rsp_vertex_out,
   output logic [VAL_W-1:0]    rsp_rank_value,
   output logic [VAL_W-1:0]    rsp_residual,
   output logic [1:0]          rsp_status,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [DAMP_W-1:0]   csr_write_data
);

   // One-hot sequencer states. The run walks copy, then per vertex a row fetch,
   // an edge loop of four steps per edge, and a two-step blend.
   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_COPY_RD  = 12'b0000_0000_0010,
      S_COPY_WR  = 12'b0000_0000_0100,
      S_ROW_RD   = 12'b0000_0000_1000,
      S_ROW_LAT  = 12'b0000_0001_0000,
      S_EDGE_RD  = 12'b0000_0010_0000,
      S_EDGE_NB  = 12'b0000_0100_0000,
      S_EDGE_MUL = 12'b0000_1000_0000,
      S_EDGE_ACC = 12'b0001_0000_0000,
      S_MIX      = 12'b0010_0000_0000,
      S_BLEND    = 12'b0100_0000_0000,
      S_READ     = 12'b1000_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [DAMP_W-1:0]    damping_ff, damping_in;
   logic [ITER_W-1:0]    iters_cfg_ff, iters_cfg_in;
   logic [VCNT_W-1:0]    vcount_ff, vcount_in;
   logic [ECNT_W-1:0]    ecount_ff, ecount_in;
   logic                 cur_buf_ff, cur_buf_in;
   logic                 valid_ff, valid_in;
   logic [VAL_W-1:0]     last_resid_ff, last_resid_in;

   logic [DAMP_W-1:0]    d_ff, d_in;
   logic [ITER_W-1:0]    iters_ff, iters_in;
   logic [ITER_W-1:0]    it_ff, it_in;
   logic                 par_ff, par_in;
   logic [VCNT_W-1:0]    i_ff, i_in;
   logic [ECNT_W-1:0]    beg_ff, beg_in;
   logic [ECNT_W-1:0]    end_ff, end_in;
   logic [ECNT_W-1:0]    p_ff, p_in;
   logic [VAL_W-1:0]     curi_ff, curi_in;
   logic [VAL_W-1:0]     prior_ff, prior_in;
   logic                 nb_ok_ff, nb_ok_in;
   logic [VAL_W-1:0]     w_ff, w_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [MIX_W-1:0]     m1_ff, m1_in, m2_ff, m2_in;
   logic [RESID_W-1:0]   resid_ff, resid_in;

   logic                 strobe_ff, strobe_in;
   logic [VIDX_W-1:0]    vout_ff, vout_in;
   logic [VAL_W-1:0]     rank_ff, rank_in;
   logic [VAL_W-1:0]     rresid_ff, rresid_in;
   status_type           status_ff, status_in;

   // Memory ports.
   logic                 prior_we, rowend_we, edge_we, ra_we, rb_we;
   logic [VIDX_W-1:0]    prior_wa, rowend_wa, ra_wa, rb_wa, vidx_ra, rank_ra;
   logic [ECNT_W-1:0]    rowend_wd;
   logic [VAL_W-1:0]     ra_wd, rb_wd;
   logic [EIDX_W-1:0]    edge_wa, edge_ra;
   logic [VAL_W-1:0]     prior_q, ra_q, rb_q, wt_q, cur_q;
   logic [ECNT_W-1:0]    rowend_q;
   logic [VIDX_W-1:0]    nb_q;

   logic                 accept;
   opcode_type           op;
   logic [VAL_W-1:0]     new_rank, diff;
   logic [MIX_W:0]       blend_sum;
   logic [RESID_W-1:0]   resid_next;
   logic [ECNT_W-1:0]    row_end_clamped;

   assign accept = start && !busy;
   assign op     = opcode_type'(req_opcode);
   assign busy   = (state_ff != S_IDLE);

   // The current rank buffer of the iteration is A on even parity.
   assign cur_q = par_ff ? rb_q : ra_q;

   assign blend_sum = {1'b0, m1_ff} + {1'b0, m2_ff};
   assign new_rank  = (blend_sum[MIX_W:15+VAL_W] != '0) ? '1 : blend_sum[15 +: VAL_W];
   assign diff      = (new_rank >= curi_ff) ? new_rank - curi_ff : curi_ff - new_rank;
   assign resid_next = resid_ff + RESID_W'(diff);
   assign row_end_clamped = (rowend_q > ecount_ff) ? ecount_ff : rowend_q;

   // Read addresses follow the sequencer; in idle the rank memories look up the
   // read request's vertex so that the data is ready in the next cycle.
   always_comb begin
      vidx_ra = i_ff[VIDX_W-1:0];
      edge_ra = p_ff[EIDX_W-1:0];
      unique case (state_ff)
         S_IDLE:    rank_ra = req_vertex_index;
         S_EDGE_NB: rank_ra = nb_q;
         default:   rank_ra = i_ff[VIDX_W-1:0];
      endcase
   end

   always_comb begin
      prior_we  = 1'b0;
      prior_wa  = vcount_ff[VIDX_W-1:0];
      rowend_we = 1'b0;
      rowend_wa = vcount_ff[VIDX_W-1:0];
      rowend_wd = ecount_ff;
      edge_we   = 1'b0;
      edge_wa   = ecount_ff[EIDX_W-1:0];
      ra_we     = 1'b0;
      ra_wa     = i_ff[VIDX_W-1:0];
      ra_wd     = new_rank;
      rb_we     = 1'b0;
      rb_wa     = i_ff[VIDX_W-1:0];
      rb_wd     = new_rank;

      damping_in    = damping_ff;
      iters_cfg_in  = iters_cfg_ff;
      vcount_in     = vcount_ff;
      ecount_in     = ecount_ff;
      cur_buf_in    = cur_buf_ff;
      valid_in      = valid_ff;
      last_resid_in = last_resid_ff;
      state_in      = state_ff;
      d_in          = d_ff;
      iters_in      = iters_ff;
      it_in         = it_ff;
      par_in        = par_ff;
      i_in          = i_ff;
      beg_in        = beg_ff;
      end_in        = end_ff;
      p_in          = p_ff;
      curi_in       = curi_ff;
      prior_in      = prior_ff;
      nb_ok_in      = nb_ok_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      resid_in      = resid_ff;
      strobe_in     = 1'b0;
      vout_in       = '0;
      rank_in       = '0;
      rresid_in     = '0;
      status_in     = ST_OK;

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DAMPING: damping_in   = csr_write_data;
            CSR_ITERS:   iters_cfg_in = csr_write_data[ITER_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               unique case (op)
                  OP_CLEAR: begin
                     vcount_in = '0;
                     ecount_in = '0;
                     valid_in  = 1'b0;
                  end
                  OP_VERTEX: begin
                     valid_in = 1'b0;
                     if (vcount_ff >= VCNT_W'(MAX_VERTICES)) begin
                        status_in = ST_FULL;
                     end else begin
                        prior_we  = 1'b1;
                        rowend_we = 1'b1;
                        vcount_in = vcount_ff + 1'b1;
                     end
                  end
                  OP_EDGE: begin
                     valid_in = 1'b0;
                     if (vcount_ff == '0) begin
                        status_in = ST_RANGE;
                     end else if (ecount_ff >= ECNT_W'(MAX_EDGES)) begin
                        status_in = ST_FULL;
                     end else begin
                        edge_we   = 1'b1;
                        ecount_in = ecount_ff + 1'b1;
                        rowend_we = 1'b1;
                        rowend_wa = VIDX_W'(vcount_ff - 1'b1);
                        rowend_wd = ecount_ff + 1'b1;
                     end
                  end
                  OP_RUN: begin
                     d_in     = (damping_ff > ONE_Q15) ? ONE_Q15 : damping_ff;
                     iters_in = (iters_cfg_ff == '0) ? ITER_W'(1) : iters_cfg_ff;
                     i_in     = '0;
                     if (vcount_ff == '0) begin
                        // Nothing to iterate over: the run is valid at once.
                        valid_in      = 1'b1;
                        last_resid_in = '0;
                        cur_buf_in    = (iters_cfg_ff == '0) ? 1'b1 : iters_cfg_ff[0];
                     end else begin
                        strobe_in = 1'b0;
                        state_in  = S_COPY_RD;
                     end
                  end
                  OP_READ: begin
                     if (!valid_ff) begin
                        status_in = ST_NO_RES;
                     end else if (VCNT_W'(req_vertex_index) >= vcount_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        strobe_in = 1'b0;
                        vout_in   = req_vertex_index;
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            strobe_in = 1'b1;
            vout_in   = vout_ff;
            rank_in   = cur_buf_ff ? rb_q : ra_q;
            rresid_in = last_resid_ff;
            state_in  = S_IDLE;
         end
         S_COPY_RD: state_in = S_COPY_WR;
         S_COPY_WR: begin
            ra_we = 1'b1;
            ra_wd = prior_q;
            i_in  = i_ff + 1'b1;
            if (i_ff + 1'b1 == vcount_ff) begin
               i_in     = '0;
               beg_in   = '0;
               resid_in = '0;
               it_in    = '0;
               par_in   = 1'b0;
               state_in = S_ROW_RD;
            end else begin
               state_in = S_COPY_RD;
            end
         end
         S_ROW_RD: state_in = S_ROW_LAT;
         S_ROW_LAT: begin
            curi_in  = cur_q;
            prior_in = prior_q;
            end_in   = row_end_clamped;
            acc_in   = '0;
            p_in     = beg_ff;
            state_in = (beg_ff < row_end_clamped) ? S_EDGE_RD : S_MIX;
         end
         S_EDGE_RD: state_in = S_EDGE_NB;
         S_EDGE_NB: begin
            nb_ok_in = (VCNT_W'(nb_q) < vcount_ff);
            w_in     = wt_q;
            state_in = S_EDGE_MUL;
         end
         S_EDGE_MUL: begin
            prod_in  = nb_ok_ff ? cur_q * w_ff : '0;
            state_in = S_EDGE_ACC;
         end
         S_EDGE_ACC: begin
            acc_in   = acc_ff + ACC_W'(prod_ff[PROD_W-1:30]);
            p_in     = p_ff + 1'b1;
            state_in = (p_ff + 1'b1 < end_ff) ? S_EDGE_RD : S_MIX;
         end
         S_MIX: begin
            m1_in    = d_ff * sat_acc(acc_ff);
            m2_in    = (ONE_Q15 - d_ff) * prior_ff;
            state_in = S_BLEND;
         end
         S_BLEND: begin
            ra_we    = par_ff;
            rb_we    = !par_ff;
            resid_in = resid_next;
            if (end_ff > beg_ff) begin
               beg_in = end_ff;
            end
            i_in     = i_ff + 1'b1;
            state_in = S_ROW_RD;
            if (i_ff + 1'b1 == vcount_ff) begin
               if (it_ff + 1'b1 < iters_ff) begin
                  it_in    = it_ff + 1'b1;
                  par_in   = !par_ff;
                  i_in     = '0;
                  beg_in   = '0;
                  resid_in = '0;
               end else begin
                  // The buffer just written becomes the current one.
                  cur_buf_in    = !par_ff;
                  last_resid_in = sat_resid(resid_next);
                  valid_in      = 1'b1;
                  strobe_in     = 1'b1;
                  rresid_in     = sat_resid(resid_next);
                  state_in      = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         damping_ff    <= DAMP_RESET;
         iters_cfg_ff  <= ITER_RESET;
         vcount_ff     <= '0;
         ecount_ff     <= '0;
         cur_buf_ff    <= 1'b0;
         valid_ff      <= 1'b0;
         last_resid_ff <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         damping_ff    <= damping_in;
         iters_cfg_ff  <= iters_cfg_in;
         vcount_ff     <= vcount_in;
         ecount_ff     <= ecount_in;
         cur_buf_ff    <= cur_buf_in;
         valid_ff      <= valid_in;
         last_resid_ff <= last_resid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff      <= d_in;
      iters_ff  <= iters_in;
      it_ff     <= it_in;
      par_ff    <= par_in;
      i_ff      <= i_in;
      beg_ff    <= beg_in;
      end_ff    <= end_in;
      p_ff      <= p_in;
      curi_ff   <= curi_in;
      prior_ff  <= prior_in;
      nb_ok_ff  <= nb_ok_in;
      w_ff      <= w_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      resid_ff  <= resid_in;
      vout_ff   <= vout_in;
      rank_ff   <= rank_in;
      rresid_ff <= rresid_in;
      status_ff <= status_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_vertex_out = vout_ff;
   assign rsp_rank_value = rank_ff;
   assign rsp_residual   = rresid_ff;
   assign rsp_status     = status_ff;

   prpi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES)) u_prior (
      .clock(clock), .wr_en(prior_we), .wr_addr(prior_wa), .wr_data(req_prior_value),
      .rd_addr(vidx_ra), .rd_data(prior_q));

   prpi_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_VERTICES)) u_row_end (
      .clock(clock), .wr_en(rowend_we), .wr_addr(rowend_wa), .wr_data(rowend_wd),
      .rd_addr(vidx_ra), .rd_data(rowend_q));

   prpi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES)) u_rank_a (
      .clock(clock), .wr_en(ra_we), .wr_addr(ra_wa), .wr_data(ra_wd),
      .rd_addr(rank_ra), .rd_data(ra_q));

   prpi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES)) u_rank_b (
      .clock(clock), .wr_en(rb_we), .wr_addr(rb_wa), .wr_data(rb_wd),
      .rd_addr(rank_ra), .rd_data(rb_q));

   prpi_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_EDGES)) u_neighbor (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(req_neighbor),
      .rd_addr(edge_ra), .rd_data(nb_q));

   prpi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_EDGES)) u_weight (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(req_edge_weight),
      .rd_addr(edge_ra), .rd_data(wt_q));

   // A run on a loaded graph must hold the block busy in the next cycle.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_RUN && vcount_ff != '0) |=> busy)
      else $error("run request did not start the sequencer");

   // Responses only appear once the sequencer is back in idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // The vertex count never passes the store depth.
   a_vcount: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= VCNT_W'(MAX_VERTICES))
      else $error("vertex count overflow");

endmodule

// ----- tb/tb_top.sv -----
`default_nettype none

// Self-checking bench for the PageRank power iteration unit.
// Requests come from a queue of pending requests that the stimulus block fills.
// A driver applies them at the falling edge and holds each one until the unit
// takes it, which is at a rising edge with start high and busy low. Every
// request yields exactly one response strobe. A bit-exact predictor keeps its
// own copy of the graph, the rank buffers and the two control registers, and
// computes each response at the edge where its request is taken.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import prpi_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   typedef struct {
      logic [2:0]        opcode;
      logic [VAL_W-1:0]  prior_value;
      logic [VIDX_W-1:0] neighbor;
      logic [VAL_W-1:0]  edge_weight;
      logic [VIDX_W-1:0] vertex_index;
   } graph_req_t;

   typedef struct {
      logic [VIDX_W-1:0] vertex_out;
      logic [VAL_W-1:0]  rank_value;
      logic [VAL_W-1:0]  residual;
      logic [1:0]        status;
   } rank_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0]        req_opcode = '0;
   logic [VAL_W-1:0]  req_prior_value = '0;
   logic [VIDX_W-1:0] req_neighbor = '0;
   logic [VAL_W-1:0]  req_edge_weight = '0;
   logic [VIDX_W-1:0] req_vertex_index = '0;
   logic              rsp_strobe;
   logic [VIDX_W-1:0] rsp_vertex_out;
   logic [VAL_W-1:0]  rsp_rank_value;
   logic [VAL_W-1:0]  rsp_residual;
   logic [1:0]        rsp_status;
   logic              csr_write_enable = 1'b0;
   logic              csr_index = 1'b0;
   logic [DAMP_W-1:0] csr_write_data = '0;

   pagerank_power_iteration_unit DUT (.*);

   always #5 clock = ~clock;

   // Predictor state: graph stores, both rank buffers and the registers.
   logic [VAL_W-1:0]  prior_mem [MAX_VERTICES];
   logic [VAL_W-1:0]  rank_a    [MAX_VERTICES];
   logic [VAL_W-1:0]  rank_b    [MAX_VERTICES];
   logic [ECNT_W-1:0] row_end   [MAX_VERTICES];
   logic [VIDX_W-1:0] nbr_mem   [MAX_EDGES];
   logic [VAL_W-1:0]  wgt_mem   [MAX_EDGES];
   int unsigned vtx_count = 0;
   int unsigned edge_count = 0;
   bit          rank_in_b = 0;
   bit          ranks_ready = 0;
   logic [VAL_W-1:0]  last_resid = '0;
   logic [DAMP_W-1:0] damping_reg = DAMP_RESET;
   logic [ITER_W-1:0] iters_reg = ITER_RESET;

   graph_req_t pending_reqs [$];
   rank_rsp_t  expected_rsps [$];
   bit   taken = 0;
   bit   steady = 0;
   int   errors = 0;
   int   cycles = 0;

   function automatic logic [VAL_W-1:0] clip32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? '1 : v[VAL_W-1:0];
   endfunction

   // One run: seed the ranks with the priors, then iterate. Reading from one
   // buffer and writing the other, the buffers swap after every pass.
   task automatic run_power_iteration();
      int unsigned d, passes, it, i, p, beg, fin;
      logic [63:0] acc, mix, resid, old_rank, prod;
      logic [VAL_W-1:0] r;
      bit in_b;
      d = (damping_reg > ONE_Q15) ? ONE_Q15 : damping_reg;
      passes = (iters_reg == 0) ? 1 : iters_reg;
      for (i = 0; i < vtx_count; i++) rank_a[i] = prior_mem[i];
      in_b = 0;
      resid = '0;
      for (it = 0; it < passes; it++) begin
         beg = 0;
         resid = '0;
         for (i = 0; i < vtx_count; i++) begin
            fin = row_end[i];
            if (fin > edge_count) fin = edge_count;
            acc = '0;
            for (p = beg; p < fin; p++) begin
               // Edges from vertices that are not loaded contribute nothing.
               if (nbr_mem[p] < vtx_count) begin
                  old_rank = in_b ? rank_b[nbr_mem[p]] : rank_a[nbr_mem[p]];
                  prod = old_rank * {32'd0, wgt_mem[p]};
                  acc += prod >> 30;
               end
            end
            if (fin > beg) beg = fin;
            mix = 64'(d) * 64'(clip32(acc)) + 64'(ONE_Q15 - d) * 64'(prior_mem[i]);
            r = clip32(mix >> 15);
            old_rank = in_b ? rank_b[i] : rank_a[i];
            if (in_b) rank_a[i] = r;
            else rank_b[i] = r;
            resid += (r >= old_rank) ? (64'(r) - old_rank) : (old_rank - 64'(r));
         end
         in_b = ~in_b;
      end
      rank_in_b = in_b;
      last_resid = clip32(resid);
      ranks_ready = 1;
   endtask

   task automatic predict_response(input graph_req_t q);
      rank_rsp_t e;
      e = '{default: '0};
      case (q.opcode)
         OP_CLEAR: begin
            vtx_count = 0;
            edge_count = 0;
            ranks_ready = 0;
         end
         OP_VERTEX: begin
            ranks_ready = 0;
            if (vtx_count >= MAX_VERTICES) e.status = ST_FULL;
            else begin
               prior_mem[vtx_count] = q.prior_value;
               row_end[vtx_count] = ECNT_W'(edge_count);
               vtx_count++;
            end
         end
         OP_EDGE: begin
            ranks_ready = 0;
            if (vtx_count == 0) e.status = ST_RANGE;
            else if (edge_count >= MAX_EDGES) e.status = ST_FULL;
            else begin
               nbr_mem[edge_count] = q.neighbor;
               wgt_mem[edge_count] = q.edge_weight;
               edge_count++;
               row_end[vtx_count - 1] = ECNT_W'(edge_count);
            end
         end
         OP_RUN: begin
            run_power_iteration();
            e.residual = last_resid;
         end
         OP_READ: begin
            if (!ranks_ready) e.status = ST_NO_RES;
            else if (q.vertex_index >= vtx_count) e.status = ST_RANGE;
            else begin
               e.vertex_out = q.vertex_index;
               e.rank_value = rank_in_b ? rank_b[q.vertex_index] : rank_a[q.vertex_index];
               e.residual = last_resid;
            end
         end
         default: ;
      endcase
      expected_rsps.push_back(e);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      errors++;
   endtask

   // Driver. A request stays on the ports until the unit takes it; the next one
   // goes out only after that. About 30 of 100 slots stay empty unless the
   // stimulus block has asked for a steady stream.
   always @(negedge clock) begin
      graph_req_t q;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (pending_reqs.size() > 0 && (steady || $urandom_range(0, 99) >= 30)) begin
            q = pending_reqs.pop_front();
            start <= 1'b1;
            req_opcode <= q.opcode;
            req_prior_value <= q.prior_value;
            req_neighbor <= q.neighbor;
            req_edge_weight <= q.edge_weight;
            req_vertex_index <= q.vertex_index;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. The response check comes first: a response never belongs to a
   // request taken at the same edge.
   always @(posedge clock) begin
      graph_req_t q;
      rank_rsp_t e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top NOT OK");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with none outstanding, status", rsp_status, 0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_vertex_out !== e.vertex_out)
                  report_mismatch("vertex_out", rsp_vertex_out, e.vertex_out);
               if (rsp_rank_value !== e.rank_value)
                  report_mismatch("rank_value", rsp_rank_value, e.rank_value);
               if (rsp_residual !== e.residual)
                  report_mismatch("residual", rsp_residual, e.residual);
               if (rsp_status !== e.status)
                  report_mismatch("status", rsp_status, e.status);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_DAMPING) damping_reg = csr_write_data;
            else iters_reg = csr_write_data[ITER_W-1:0];
         end
         if (start && !busy) begin
            q.opcode = req_opcode;
            q.prior_value = req_prior_value;
            q.neighbor = req_neighbor;
            q.edge_weight = req_edge_weight;
            q.vertex_index = req_vertex_index;
            predict_response(q);
         end
         taken <= start && !busy;
      end else begin
         taken <= 1'b0;
      end
   end

   task automatic add_req(input logic [2:0] op, input logic [31:0] prior_v,
                          input logic [9:0] nb, input logic [31:0] w,
                          input logic [9:0] vi);
      graph_req_t q;
      q.opcode = op;
      q.prior_value = prior_v;
      q.neighbor = nb;
      q.edge_weight = w;
      q.vertex_index = vi;
      pending_reqs.push_back(q);
   endtask

   // Registers are only written once every request has been answered.
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [DAMP_W-1:0] value);
      wait_idle();
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [31:0] rand_value();
      // Mostly values up to about one, so ranks do not saturate at once.
      return ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h4800_0000);
   endfunction

   // Well-formed graphs with random content, plus some stray requests.
   task automatic random_phase(input int count);
      int added, v, n, k, j;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 99) < 85) begin
            v = $urandom_range(1, 8);
            add_req(OP_CLEAR, $urandom(), 10'($urandom()), $urandom(), 10'($urandom()));
            for (k = 0; k < v; k++) begin
               add_req(OP_VERTEX, rand_value(), 10'($urandom()), $urandom(),
                       10'($urandom()));
               n = $urandom_range(0, 3);
               for (j = 0; j < n; j++)
                  add_req(OP_EDGE, $urandom(),
                          ($urandom_range(0, 9) == 0) ? 10'($urandom()) : 10'($urandom_range(0, v)),
                          rand_value(), 10'($urandom()));
               added += n + 1;
            end
            add_req(OP_RUN, $urandom(), 10'($urandom()), $urandom(), 10'($urandom()));
            n = $urandom_range(1, 4);
            for (j = 0; j < n; j++)
               add_req(OP_READ, $urandom(), 10'($urandom()), $urandom(),
                       ($urandom_range(0, 5) == 0) ? 10'($urandom()) : 10'($urandom_range(0, v - 1)));
            added += n + 2;
         end else begin
            add_req(3'($urandom_range(0, 7)), $urandom(), 10'($urandom()), $urandom(),
                    10'($urandom()));
            added++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset settings: reads before any run, an edge with no
      // vertex, extreme priors and weights, an edge from an unloaded vertex,
      // unknown opcodes, and a load that invalidates the ranks again.
      add_req(OP_CLEAR, '0, '0, '0, '0);
      add_req(OP_READ, '0, '0, '0, '0);
      add_req(OP_EDGE, '1, '1, '1, '1);
      add_req(OP_VERTEX, '0, '0, '0, '0);
      add_req(OP_EDGE, '0, 10'd1, '1, '0);
      add_req(OP_VERTEX, '1, '1, '1, '1);
      add_req(OP_EDGE, '0, 10'd0, 32'h4000_0000, '0);
      add_req(OP_EDGE, '0, 10'd1023, 32'h4000_0000, '0);
      add_req(OP_EDGE, '0, 10'd1, '0, '0);
      add_req(OP_VERTEX, 32'h2000_0000, '0, '0, '0);
      add_req(OP_RUN, '0, '0, '0, '0);
      add_req(OP_READ, '0, '0, '0, 10'd0);
      add_req(OP_READ, '0, '0, '0, 10'd2);
      add_req(OP_READ, '0, '0, '0, 10'd3);
      add_req(OP_READ, '1, '1, '1, 10'd1023);
      add_req(OP_READ + 3'd1, '1, '1, '1, '1);
      add_req(OP_READ + 3'd2, '0, '0, '0, '0);
      add_req(OP_READ + 3'd3, '1, '1, '1, '1);
      add_req(OP_VERTEX, 32'h1234_5678, '0, '0, '0);
      add_req(OP_READ, '0, '0, '0, 10'd0);
      add_req(OP_CLEAR, '0, '0, '0, '0);
      add_req(OP_RUN, '0, '0, '0, '0);
      add_req(OP_READ, '0, '0, '0, 10'd0);

      // Extremes of both registers, then random graphs under several settings.
      write_csr(CSR_ITERS, 16'd255);
      write_csr(CSR_DAMPING, 16'd0);
      random_phase(15);
      write_csr(CSR_ITERS, 16'd3);
      write_csr(CSR_DAMPING, 16'(ONE_Q15));
      random_phase(15);
      write_csr(CSR_ITERS, 16'd0);
      write_csr(CSR_DAMPING, 16'hFFFF);
      random_phase(15);
      wait_idle();
      steady = 1;
      write_csr(CSR_ITERS, 16'd1);
      write_csr(CSR_DAMPING, 16'($urandom_range(1, 32767)));
      random_phase(15);
      wait_idle();
      steady = 0;
      write_csr(CSR_ITERS, 16'($urandom_range(2, 6)));
      write_csr(CSR_DAMPING, 16'($urandom()));
      random_phase(15);

      wait_idle();
      repeat (20) @(negedge clock);
      if (errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/prpi_pkg.sv
rtl/prpi_ram.sv
rtl/pagerank_power_iteration_unit.sv
tb/tb_top.sv
